// File: src/cpr_pkg.sv
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared constants, types and helpers for the clock page replacement unit.
// ----------------------------------------------------------------------------
package cpr_pkg;

	localparam int FRAMES   = 16;
	localparam int IDX_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CNT_W    = $clog2(FRAMES + 1);
	localparam int PAGE_W   = 20;
	localparam int FIDX_W   = 4;
	localparam int CTR_W    = 32;
	localparam int CFG_W    = 5;
	localparam int CFG_RST  = 16;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 96;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_START,
		CMD_SCAN,
		CMD_HIT,
		CMD_FILL,
		CMD_SWEEP,
		CMD_VREAD,
		CMD_EVICT
	} cpr_op_t;

	typedef struct packed {
		cpr_op_t op;
	} cpr_cmd_t;

	typedef struct packed {
		logic hit_now;
		logic scan_last;
		logic hit_found;
		logic free_found;
		logic ref_at_hand;
		logic out_free;
	} cpr_status_t;

	function automatic logic [FIDX_W-1:0] to_fidx(input logic [IDX_W-1:0] idx);
		logic [IDX_W+FIDX_W-1:0] wide;
		wide = {{FIDX_W{1'b0}}, idx};
		return wide[FIDX_W-1:0];
	endfunction

endpackage

// File: src/cpr_ram.sv
// ----------------------------------------------------------------------------
// cpr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cpr_ram #(
	parameter int W = 20,
	parameter int D = 16,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/cpr_ctrl.sv
// ----------------------------------------------------------------------------
// cpr_ctrl
// Sequencer: tag scan, decision, clock sweep and commit of one access.
// ----------------------------------------------------------------------------
module cpr_ctrl import cpr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  cpr_status_t stat,
	output cpr_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_HIT,
		ST_FILL,
		ST_SWEEP,
		ST_EVICT
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   rdy_q;
	logic   rdy_nxt;

	always_comb begin
		state_nxt = state_q;
		rdy_nxt   = rdy_q;
		cmd.op    = CMD_NONE;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.op    = CMD_START;
					state_nxt = ST_SCAN;
					rdy_nxt   = 1'b0;
				end
			end
			ST_SCAN: begin
				cmd.op = CMD_SCAN;
				if (stat.hit_now || stat.scan_last) begin
					state_nxt = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (stat.hit_found) begin
					state_nxt = ST_HIT;
				end else if (stat.free_found) begin
					state_nxt = ST_FILL;
				end else begin
					state_nxt = ST_SWEEP;
				end
			end
			ST_HIT: begin
				if (stat.out_free) begin
					cmd.op    = CMD_HIT;
					state_nxt = ST_IDLE;
					rdy_nxt   = 1'b1;
				end
			end
			ST_FILL: begin
				if (stat.out_free) begin
					cmd.op    = CMD_FILL;
					state_nxt = ST_IDLE;
					rdy_nxt   = 1'b1;
				end
			end
			ST_SWEEP: begin
				if (stat.ref_at_hand) begin
					cmd.op = CMD_SWEEP;
				end else begin
					cmd.op    = CMD_VREAD;
					state_nxt = ST_EVICT;
				end
			end
			ST_EVICT: begin
				if (stat.out_free) begin
					cmd.op    = CMD_EVICT;
					state_nxt = ST_IDLE;
					rdy_nxt   = 1'b1;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
				rdy_nxt   = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rdy_q   <= 1'b1;
		end else begin
			state_q <= state_nxt;
			rdy_q   <= rdy_nxt;
		end
	end

	assign s_tready = rdy_q;

endmodule

// File: src/cpr_dp.sv
// ----------------------------------------------------------------------------
// cpr_dp
// Datapath: page RAM, valid and reference bits, hand, counters, result beat.
// ----------------------------------------------------------------------------
module cpr_dp import cpr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [CFG_W-1:0]    cfg_wr_data,
	input  logic [PAGE_W-1:0]   in_page,
	input  cpr_cmd_t            cmd,
	output cpr_status_t         stat,
	input  logic                m_tready,
	output logic                m_tvalid,
	output logic [M_DATA_W-1:0] m_tdata
);

	logic [CFG_W-1:0]  cfg_q;
	logic [CNT_W-1:0]  n_eff;
	logic [CNT_W-1:0]  n_q;
	logic [PAGE_W-1:0] page_q;
	logic [IDX_W-1:0]  hand_q;
	logic [IDX_W-1:0]  hand_adv;
	logic [FRAMES-1:0] valid_q;
	logic [FRAMES-1:0] ref_q;
	logic [CTR_W-1:0]  hits_q;
	logic [CTR_W-1:0]  faults_q;
	logic [CTR_W-1:0]  hits_inc;
	logic [CTR_W-1:0]  faults_inc;
	logic [CNT_W-1:0]  scan_cnt_q;
	logic              scan_issue;
	logic              pipe_vld_s1;
	logic [IDX_W-1:0]  pipe_idx_s1;
	logic              hit_q;
	logic [IDX_W-1:0]  slot_q;
	logic              free_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic              hit_now;
	logic              free_now;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;
	logic [PAGE_W-1:0] ram_rdata;

	logic              out_vld_q;
	logic              res_hit_q;
	logic [FIDX_W-1:0] res_frame_q;
	logic              res_evict_q;
	logic [PAGE_W-1:0] res_evpage_q;
	logic [CTR_W-1:0]  res_hits_q;
	logic [CTR_W-1:0]  res_faults_q;

	always_comb begin
		if (cfg_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (int'(cfg_q) > FRAMES) begin
			n_eff = CNT_W'(FRAMES);
		end else begin
			n_eff = CNT_W'(cfg_q);
		end
	end

	assign hand_adv   = (int'(hand_q) + 1 >= int'(n_q)) ? '0 : hand_q + 1'b1;
	assign hits_inc   = (&hits_q) ? hits_q : hits_q + 1'b1;
	assign faults_inc = (&faults_q) ? faults_q : faults_q + 1'b1;
	assign scan_issue = (cmd.op == CMD_SCAN) && (scan_cnt_q < n_q);
	assign hit_now    = pipe_vld_s1 && valid_q[pipe_idx_s1] && (ram_rdata == page_q);
	assign free_now   = pipe_vld_s1 && !valid_q[pipe_idx_s1];

	assign stat.hit_now     = hit_now;
	assign stat.scan_last   = pipe_vld_s1 && (CNT_W'(pipe_idx_s1) == n_q - 1'b1);
	assign stat.hit_found   = hit_q;
	assign stat.free_found  = free_q;
	assign stat.ref_at_hand = ref_q[hand_q];
	assign stat.out_free    = !out_vld_q || m_tready;

	assign ram_we    = (cmd.op == CMD_FILL) || (cmd.op == CMD_EVICT);
	assign ram_waddr = (cmd.op == CMD_FILL) ? free_idx_q : hand_q;
	assign ram_re    = scan_issue || (cmd.op == CMD_VREAD);
	assign ram_raddr = (cmd.op == CMD_VREAD) ? hand_q : scan_cnt_q[IDX_W-1:0];

	cpr_ram #(
		.W(PAGE_W),
		.D(FRAMES)
	) u_page_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (page_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= CFG_W'(CFG_RST);
			hand_q      <= '0;
			valid_q     <= '0;
			ref_q       <= '0;
			hits_q      <= '0;
			faults_q    <= '0;
			pipe_vld_s1 <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cfg_q <= cfg_wr_data;
			end
			if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			pipe_vld_s1 <= scan_issue;
			case (cmd.op)
				CMD_START: begin
					if (int'(hand_q) >= int'(n_eff)) begin
						hand_q <= '0;
					end
				end
				CMD_HIT: begin
					ref_q[slot_q] <= 1'b1;
					hits_q        <= hits_inc;
					out_vld_q     <= 1'b1;
				end
				CMD_FILL: begin
					valid_q[free_idx_q] <= 1'b1;
					ref_q[free_idx_q]   <= 1'b1;
					faults_q            <= faults_inc;
					out_vld_q           <= 1'b1;
				end
				CMD_SWEEP: begin
					ref_q[hand_q] <= 1'b0;
					hand_q        <= hand_adv;
				end
				CMD_EVICT: begin
					ref_q[hand_q] <= 1'b1;
					hand_q        <= hand_adv;
					faults_q      <= faults_inc;
					out_vld_q     <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// scan flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (cmd.op == CMD_START) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (cmd.op == CMD_SCAN) begin
			if (hit_now && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (free_now && !free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		pipe_idx_s1 <= scan_cnt_q[IDX_W-1:0];
		case (cmd.op)
			CMD_START: begin
				page_q     <= in_page;
				n_q        <= n_eff;
				scan_cnt_q <= '0;
			end
			CMD_SCAN: begin
				if (scan_issue) begin
					scan_cnt_q <= scan_cnt_q + 1'b1;
				end
				if (hit_now && !hit_q) begin
					slot_q <= pipe_idx_s1;
				end
				if (free_now && !free_q) begin
					free_idx_q <= pipe_idx_s1;
				end
			end
			CMD_HIT: begin
				res_hit_q    <= 1'b1;
				res_frame_q  <= to_fidx(slot_q);
				res_evict_q  <= 1'b0;
				res_evpage_q <= '0;
				res_hits_q   <= hits_inc;
				res_faults_q <= faults_q;
			end
			CMD_FILL: begin
				res_hit_q    <= 1'b0;
				res_frame_q  <= to_fidx(free_idx_q);
				res_evict_q  <= 1'b0;
				res_evpage_q <= '0;
				res_hits_q   <= hits_q;
				res_faults_q <= faults_inc;
			end
			CMD_EVICT: begin
				res_hit_q    <= 1'b0;
				res_frame_q  <= to_fidx(hand_q);
				res_evict_q  <= 1'b1;
				res_evpage_q <= ram_rdata;
				res_hits_q   <= hits_q;
				res_faults_q <= faults_inc;
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {6'b0, res_faults_q, res_hits_q, res_evpage_q,
		res_evict_q, res_frame_q, res_hit_q};

endmodule

// File: src/clock_page_replacement.sv
// ----------------------------------------------------------------------------
// clock_page_replacement
// Clock (second chance) page replacement unit with hit and fault counters.
// ----------------------------------------------------------------------------
//  channel   dir  width  contents
//  s_*       in   24     vpage[19:0]
//  m_*       out  96     was_hit, frame_no, evicted, evicted_page,
//                        hit_total, fault_total
//  cfg_wr_*  in   5      frames_in_use
//
//  One access at a time: the tag scan reads the page RAM one entry a cycle
//  and the sweep visits one frame a cycle.
//  Reset clears valid and reference bits, hand and counters at once.
//  A waiting result beat stalls only the commit step of the following access.
// ----------------------------------------------------------------------------
module clock_page_replacement import cpr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [CFG_W-1:0]    cfg_wr_data,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // [19:0] vpage
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata    // [0] was_hit, [4:1] frame_no,
	                                       // [5] evicted, [25:6] evicted_page,
	                                       // [57:26] hit_total, [89:58] fault_total
);

	cpr_cmd_t    cmd;
	cpr_status_t stat;

	cpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cpr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_page     (s_tdata[PAGE_W-1:0]),
		.cmd         (cmd),
		.stat        (stat),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.m_tdata     (m_tdata)
	);

endmodule

// File: bench/clock_page_replacement_tb.sv
// ----------------------------------------------------------------------------
// clock_page_replacement_tb
// Self-checking bench for the clock page replacement unit. A behavioural
// model of the frame table, clock hand and counters predicts every result
// beat. Directed accesses cover fill, hit, full sweep, frame count extremes,
// hand wrap and duplicate residency. Random phases at several frame counts
// follow, most with bursty input and a stalling result side.
// ----------------------------------------------------------------------------
module clock_page_replacement_tb import cpr_pkg::*;;

	typedef struct packed {
		logic              was_hit;
		logic [FIDX_W-1:0] frame_no;
		logic              evicted;
		logic [PAGE_W-1:0] evicted_page;
		logic [CTR_W-1:0]  hit_total;
		logic [CTR_W-1:0]  fault_total;
	} access_result_t;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                cfg_wr_en   = 1'b0;
	logic [CFG_W-1:0]    cfg_wr_data = '0;
	logic                s_tvalid    = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata     = '0;
	logic                m_tvalid;
	logic                m_tready    = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	// frame table model
	logic [PAGE_W-1:0] frame_page  [FRAMES] = '{default: '0};
	bit                frame_valid [FRAMES] = '{default: 1'b0};
	bit                ref_bit     [FRAMES] = '{default: 1'b0};
	int                hand        = 0;
	logic [CTR_W-1:0]  hit_count   = '0;
	logic [CTR_W-1:0]  fault_count = '0;
	logic [CFG_W-1:0]  frames_cfg  = CFG_W'(CFG_RST);

	access_result_t expected_results [$];
	int             mismatches = 0;
	int             gap_max    = 0;
	int             burst_left = 0;
	logic [15:0]    ready_mask = 16'hFFFF;
	logic [3:0]     tick       = '0;

	clock_page_replacement dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),   // [19:0] vpage
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)    // [0] was_hit, [4:1] frame_no, [5] evicted,
		                         // [25:6] evicted_page, [57:26] hit_total,
		                         // [89:58] fault_total
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		tick     <= tick + 1'b1;
		m_tready <= ready_mask[tick];
	end

	function automatic access_result_t predict_access(input logic [PAGE_W-1:0] page);
		access_result_t r;
		int             n;
		int             i;
		int             slot;
		bit             hit;
		bit             free_found;
		r          = '0;
		n          = (frames_cfg == 0) ? 1 : ((frames_cfg > FRAMES) ? FRAMES : frames_cfg);
		slot       = 0;
		hit        = 1'b0;
		free_found = 1'b0;
		if (hand >= n)
			hand = 0;
		for (i = 0; i < n; i++)
			if (!hit && frame_valid[i] && frame_page[i] == page) begin
				hit  = 1'b1;
				slot = i;
			end
		if (hit) begin
			if (hit_count != '1)
				hit_count++;
			ref_bit[slot] = 1'b1;
		end else begin
			if (fault_count != '1)
				fault_count++;
			for (i = 0; i < n; i++)
				if (!free_found && !frame_valid[i]) begin
					free_found = 1'b1;
					slot       = i;
				end
			if (!free_found) begin
				while (ref_bit[hand]) begin
					ref_bit[hand] = 1'b0;
					hand          = (hand + 1 >= n) ? 0 : hand + 1;
				end
				slot           = hand;
				r.evicted      = 1'b1;
				r.evicted_page = frame_page[slot];
				hand           = (hand + 1 >= n) ? 0 : hand + 1;
			end
			frame_page[slot]  = page;
			frame_valid[slot] = 1'b1;
			ref_bit[slot]     = 1'b1;
		end
		r.was_hit     = hit;
		r.frame_no    = slot[FIDX_W-1:0];
		r.hit_total   = hit_count;
		r.fault_total = fault_count;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
	                               input logic [63:0] want);
		$display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		access_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result beat with none pending", m_tdata[63:0], '0);
			end else begin
				want = expected_results.pop_front();
				if (m_tdata[0] !== want.was_hit)
					report_mismatch("was_hit", m_tdata[0], want.was_hit);
				if (m_tdata[4:1] !== want.frame_no)
					report_mismatch("frame_no", m_tdata[4:1], want.frame_no);
				if (m_tdata[5] !== want.evicted)
					report_mismatch("evicted", m_tdata[5], want.evicted);
				if (m_tdata[25:6] !== want.evicted_page)
					report_mismatch("evicted_page", m_tdata[25:6], want.evicted_page);
				if (m_tdata[57:26] !== want.hit_total)
					report_mismatch("hit_total", m_tdata[57:26], want.hit_total);
				if (m_tdata[89:58] !== want.fault_total)
					report_mismatch("fault_total", m_tdata[89:58], want.fault_total);
				if (m_tdata[M_DATA_W-1:90] !== '0)
					report_mismatch("padding", m_tdata[M_DATA_W-1:90], '0);
			end
		end
	end

	task automatic send_page(input logic [PAGE_W-1:0] page);
		s_tdata  <= {{(S_DATA_W-PAGE_W){1'b0}}, page};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		expected_results.push_back(predict_access(page));
		if (gap_max != 0) begin
			if (burst_left == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, gap_max)) @(posedge clk);
				burst_left = $urandom_range(0, 8);
			end else begin
				burst_left--;
			end
		end
	endtask

	// only while idle: drain all pending beats first
	task automatic write_frames(input logic [CFG_W-1:0] value);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		cfg_wr_data <= value;
		cfg_wr_en   <= 1'b1;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		frames_cfg  = value;
	endtask

	task automatic test_directed_fill();
		int k;
		gap_max    = 3;
		ready_mask = 16'hB6DB;
		send_page(20'h00000);
		send_page(20'hFFFFF);
		send_page(20'h00000);
		for (k = 1; k <= 13; k++)
			send_page({k[3:0], 16'hA5A5});
		// last free frame filled, then every reference bit set: full sweep then evict
		send_page(20'hAAAAA);
		send_page(20'h55555);
		send_page(20'hAAAAA);
	endtask

	task automatic test_register_extremes();
		logic [PAGE_W-1:0] dup_page;
		gap_max    = 0;
		ready_mask = 16'h7777;
		// zero count acts as one frame, hand wraps back inside
		write_frames('0);
		send_page(20'h12345);
		send_page(20'h12345);
		send_page(20'h00001);
		// oversize count acts as the full table
		write_frames('1);
		while (expected_results.size() != 0) @(posedge clk);
		dup_page = frame_page[FRAMES-1];
		// shrink, load a page also held in an upper frame, then grow
		write_frames(5'd2);
		send_page(dup_page);
		write_frames(5'd17);
		send_page(dup_page);
		send_page(20'h80000);
	endtask

	task automatic test_random_phases();
		logic [CFG_W-1:0]  phase_frames [10] = '{16, 1, 2, 5, 0, 31, 8, 12, 3, 16};
		logic [CFG_W-1:0]  setting;
		logic [PAGE_W-1:0] base;
		logic [PAGE_W-1:0] page;
		int                ws;
		int                p;
		int                k;
		int                roll;
		page = '0;
		for (p = 0; p < 10; p++) begin
			setting = (p == 7) ? CFG_W'($urandom_range(1, FRAMES)) : phase_frames[p];
			write_frames(setting);
			if (p == 0 || p == 6) begin
				gap_max    = 0;
				ready_mask = 16'hFFFF;
			end else begin
				gap_max    = $urandom_range(1, 16);
				ready_mask = 16'($urandom()) | (p[0] ? 16'($urandom()) : 16'h0001);
				if (p == 3)
					ready_mask = 16'($urandom() & $urandom()) | 16'h0100;
			end
			base = PAGE_W'($urandom());
			ws   = $urandom_range(2, 20);
			for (k = 0; k < 40; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 70)
					page = base + PAGE_W'($urandom_range(0, ws - 1));
				else if (roll >= 85)
					page = PAGE_W'($urandom());
				send_page(page);
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed_fill();
		test_register_extremes();
		test_random_phases();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule

// File: filelist.f
src/cpr_pkg.sv
src/cpr_ram.sv
src/cpr_ctrl.sv
src/cpr_dp.sv
src/clock_page_replacement.sv
bench/clock_page_replacement_tb.sv
